@@ hdl/sfd_pkg.sv @@
// Shared types and constants for the serial frame deframer.
package sfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 10;
    localparam int LEN_W       = 17;
    localparam int HDR_BYTES   = 10;
    localparam int LEN_LO_IDX  = 6;
    localparam int LEN_HI_IDX  = 7;

    localparam int OQ_DEPTH    = 3;
    localparam int OQ_PTR_W    = 2;
    localparam int OQ_CNT_W    = 2;

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_SEL_BIT = 2;

    typedef enum logic {
        CMD_RX   = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef enum logic {
        REG_SYNC_FIRST  = 1'b0,
        REG_SYNC_SECOND = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
    } t_cfg;

    typedef struct packed {
        logic             vld;
        logic             is_read;
        logic             oob;
        logic [CNT_W-1:0] frame_length;
    } t_evt;

    typedef struct packed {
        logic              is_read_reply;
        logic [CNT_W-1:0]  frame_length;
        logic [BYTE_W-1:0] read_data;
    } t_result;

endpackage

@@ hdl/sfd_ifs.sv @@
// Valid/ready channel interfaces for the deframer input and result beats.
interface sfd_in_if import sfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [BYTE_W-1:0] rx_byte;
    logic [CNT_W-1:0]  read_index;

    modport source (output valid, cmd, rx_byte, read_index, input ready);
    modport sink   (input valid, cmd, rx_byte, read_index, output ready);
endinterface

interface sfd_out_if import sfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              is_read_reply;
    logic [CNT_W-1:0]  frame_length;
    logic [BYTE_W-1:0] read_data;

    modport source (output valid, is_read_reply, frame_length, read_data, input ready);
    modport sink   (input valid, is_read_reply, frame_length, read_data, output ready);
endinterface

@@ hdl/sfd_cfg.sv @@
// APB-style register file holding the two sync word bytes.
module sfd_cfg import sfd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [BYTE_W-1:0] r_sync_first;
    logic [BYTE_W-1:0] r_sync_second;
    logic              wr_en;
    t_reg_idx          reg_idx;

    assign pready   = 1'b1;
    assign reg_idx  = t_reg_idx'(paddr[REG_SEL_BIT]);
    assign wr_en    = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= '0;
            r_sync_second <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SYNC_FIRST:  r_sync_first  <= pwdata[BYTE_W-1:0];
                REG_SYNC_SECOND: r_sync_second <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_SYNC_FIRST:  prdata = PDATA_W'(r_sync_first);
            REG_SYNC_SECOND: prdata = PDATA_W'(r_sync_second);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.sync_first  = r_sync_first;
    assign o_cfg.sync_second = r_sync_second;

endmodule

@@ hdl/sfd_mem.sv @@
// Frame buffer: single write port, single read port with registered data.
module sfd_mem import sfd_pkg::*; #(
    parameter int DEPTH = 522,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/sfd_ctl.sv @@
// Sync hunt, byte counting and length decode; drives the frame buffer ports.
module sfd_ctl import sfd_pkg::*; #(
    parameter int FRAME_BYTES = 522,
    parameter int AW          = $clog2(FRAME_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  logic              i_cmd,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic [CNT_W-1:0]  i_read_index,
    input  t_cfg              i_cfg,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [BYTE_W-1:0] o_wr_data,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    output t_evt              o_evt
);

    localparam logic [CNT_W-1:0] FB_CNT = CNT_W'(FRAME_BYTES);
    localparam logic [LEN_W-1:0] FB_LEN = LEN_W'(FRAME_BYTES);

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_exp, n_exp;
    logic [BYTE_W-1:0] r_len_lo;
    t_evt              r_evt, n_evt;
    logic              store;
    logic              is_rx;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  exp_upd;
    logic [LEN_W-1:0]  len;

    assign is_rx   = i_acc && (t_cmd'(i_cmd) == CMD_RX);
    assign cnt_inc = r_cnt + CNT_W'(1);
    // Length bytes are little-endian: the low byte was kept at index six,
    // the high byte is the one arriving now.
    assign len     = LEN_W'(HDR_BYTES) + {1'b0, i_rx_byte, r_len_lo};

    always_comb begin
        n_cnt   = r_cnt;
        n_exp   = r_exp;
        store   = 1'b0;
        exp_upd = r_exp;
        n_evt   = '0;
        if (i_acc && (t_cmd'(i_cmd) == CMD_READ)) begin
            n_evt.vld     = 1'b1;
            n_evt.is_read = 1'b1;
            n_evt.oob     = (i_read_index >= FB_CNT);
        end else if (is_rx) begin
            if (r_cnt == '0 && i_rx_byte != i_cfg.sync_first) begin
                n_cnt = r_cnt;
            end else if (r_cnt == CNT_W'(1) && i_rx_byte != i_cfg.sync_second) begin
                n_cnt = (i_rx_byte == i_cfg.sync_first) ? CNT_W'(1) : '0;
            end else if (r_cnt >= FB_CNT) begin
                n_cnt = '0;
                n_exp = '0;
            end else begin
                store = 1'b1;
                if (r_cnt == CNT_W'(LEN_HI_IDX) && len > FB_LEN) begin
                    n_cnt = '0;
                    n_exp = '0;
                end else begin
                    if (r_cnt == CNT_W'(LEN_HI_IDX)) begin
                        exp_upd = len[CNT_W-1:0];
                    end
                    if (exp_upd != '0 && cnt_inc == exp_upd) begin
                        n_evt.vld          = 1'b1;
                        n_evt.frame_length = cnt_inc;
                        n_cnt              = '0;
                        n_exp              = '0;
                    end else begin
                        n_cnt = cnt_inc;
                        n_exp = exp_upd;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_exp <= '0;
            r_evt <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_exp <= n_exp;
            r_evt <= n_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store && r_cnt == CNT_W'(LEN_LO_IDX)) begin
            r_len_lo <= i_rx_byte;
        end
    end

    assign o_wr_en   = store;
    assign o_wr_addr = r_cnt[AW-1:0];
    assign o_wr_data = i_rx_byte;
    assign o_rd_en   = i_acc && (t_cmd'(i_cmd) == CMD_READ);
    assign o_rd_addr = i_read_index[AW-1:0];
    assign o_evt     = r_evt;

endmodule

@@ hdl/sfd_outq.sv @@
// Three-entry result queue that drives the output channel.
module sfd_outq import sfd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_result             i_data,
    output logic [OQ_CNT_W-1:0] o_level,
    sfd_out_if.source           o_out
);

    t_result             r_data [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr, r_rd;
    logic [OQ_CNT_W-1:0] r_cnt;
    logic                pop;
    t_result             head;

    function automatic logic [OQ_PTR_W-1:0] ptr_next(input logic [OQ_PTR_W-1:0] p);
        return (p == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : p + OQ_PTR_W'(1);
    endfunction

    assign pop  = o_out.valid && o_out.ready;
    assign head = r_data[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (pop) begin
                r_rd <= ptr_next(r_rd);
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + OQ_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - OQ_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr] <= i_data;
        end
    end

    assign o_level             = r_cnt;
    assign o_out.valid         = (r_cnt != '0);
    assign o_out.is_read_reply = head.is_read_reply;
    assign o_out.frame_length  = head.frame_length;
    assign o_out.read_data     = head.read_data;

endmodule

@@ hdl/serial_frame_deframer.sv @@
// Serial frame deframer: sync hunt, length-prefixed frame capture and buffer reads.
//
// Each input beat is either a received serial byte or a read of one byte of
// the frame buffer. Received bytes are matched against a two-byte sync word
// (set through the register port); once the sync word is seen, bytes are
// written into the frame buffer, and after the eighth byte the frame length
// is taken as ten plus the little-endian 16-bit value in bytes six and seven.
// A length larger than the buffer drops the frame and restarts the hunt. When
// the last byte of a frame arrives, one result beat carries the frame length;
// a read beat always yields one result beat carrying the stored byte (zero
// for an index beyond the buffer). The block accepts one input beat every
// clock cycle while input ready is high. A result passes through the
// synchronous read of the frame buffer and then through the result queue.
// The three-entry result queue lets input keep flowing while the output side
// stalls briefly; input ready drops only once the queue and the buffer read
// stage together hold three results. The frame buffer is a plain
// FRAME_BYTES-deep byte memory with no clearing after reset, so reading a
// position that has never been written returns an arbitrary byte.
module serial_frame_deframer import sfd_pkg::*; #(
    parameter int FRAME_BYTES = 522
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    sfd_in_if.sink             i_in,
    sfd_out_if.source          o_out
);

    localparam int AW = $clog2(FRAME_BYTES);

    t_cfg                cfg;
    t_evt                evt;
    t_result             push_data;
    logic                acc;
    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [BYTE_W-1:0]   wr_data, rd_data;
    logic [OQ_CNT_W-1:0] q_level;
    logic [OQ_CNT_W:0]   occupancy;

    // Results in flight: those queued plus the one in the buffer read stage.
    assign occupancy  = {1'b0, q_level} + (OQ_CNT_W+1)'(evt.vld);
    assign i_in.ready = (occupancy < (OQ_CNT_W+1)'(OQ_DEPTH));
    assign acc        = i_in.valid && i_in.ready;

    sfd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sfd_ctl #(
        .FRAME_BYTES (FRAME_BYTES),
        .AW          (AW)
    ) u_ctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_cmd        (i_in.cmd),
        .i_rx_byte    (i_in.rx_byte),
        .i_read_index (i_in.read_index),
        .i_cfg        (cfg),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_evt        (evt)
    );

    // A write and a read never share a cycle, and a write has landed by the
    // time any later read beat reaches the memory, so no bypass is needed.
    sfd_mem #(
        .DEPTH (FRAME_BYTES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        push_data.is_read_reply = evt.is_read;
        push_data.frame_length  = evt.is_read ? '0 : evt.frame_length;
        push_data.read_data     = (evt.is_read && !evt.oob) ? rd_data : '0;
    end

    sfd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (evt.vld),
        .i_data  (push_data),
        .o_level (q_level),
        .o_out   (o_out)
    );

endmodule

@@ dv/serial_frame_deframer_test.sv @@
// Self-checking testbench for the serial frame deframer: sync hunt, frame capture and reads.
module serial_frame_deframer_test;
    import sfd_pkg::*;

    localparam int FRAME_BYTES     = 522;
    localparam int LEN_READY_COUNT = LEN_HI_IDX + 1;
    localparam int MAX_PAYLOAD     = FRAME_BYTES - HDR_BYTES;
    localparam int QUIET_LIMIT     = 2000;
    localparam int REPORT_LIMIT    = 10;
    localparam int ADDR_MAX        = (1 << CNT_W) - 1;

    // Two copies of the deframer state: one follows the stimulus as it is queued so that
    // reads only ever target buffer positions already written, the other follows the
    // beats as the block accepts them and produces the expected results.
    typedef enum int {
        GEN_COPY   = 0,
        CHECK_COPY = 1
    } t_model_copy;

    typedef struct packed {
        t_cmd              cmd;
        logic [BYTE_W-1:0] rx_byte;
        logic [CNT_W-1:0]  read_index;
    } t_serial_beat;

    typedef struct packed {
        t_serial_beat beat;
        logic         drain_first;
    } t_queued_beat;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    sfd_in_if  beat_in ();
    sfd_out_if result_out ();

    serial_frame_deframer #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (beat_in),
        .o_out   (result_out)
    );

    // Deframer state, one entry per copy.
    logic [BYTE_W-1:0] sync_first_cfg  [2];
    logic [BYTE_W-1:0] sync_second_cfg [2];
    logic [CNT_W-1:0]  frame_count     [2];
    logic [CNT_W-1:0]  frame_target    [2];
    logic [CNT_W-1:0]  store_fill      [2];
    logic [BYTE_W-1:0] frame_image     [2][FRAME_BYTES];

    t_queued_beat pending_beats[$];
    t_result      expected_results[$];

    logic drain_next = 1'b0;
    int   beats_queued = 0;
    int   beats_accepted = 0;
    int   notices_seen = 0;
    int   replies_seen = 0;
    int   settings_used = 0;
    int   error_count = 0;
    int   quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advances one copy of the deframer by one beat. Returns 1 when the beat yields a
    // result, which is then placed in res.
    function automatic bit deframe(input t_model_copy m, input t_serial_beat bt,
                                   output t_result res);
        logic [LEN_W-1:0] total;
        res = '0;
        if (bt.cmd == CMD_READ) begin
            res.is_read_reply = 1'b1;
            if (bt.read_index < FRAME_BYTES) begin
                res.read_data = frame_image[m][bt.read_index];
            end
            return 1'b1;
        end
        // While hunting, anything but the first sync byte is thrown away.
        if (frame_count[m] == 0 && bt.rx_byte != sync_first_cfg[m]) begin
            return 1'b0;
        end
        // A wrong second byte may itself be the start of a new sync word.
        if (frame_count[m] == 1 && bt.rx_byte != sync_second_cfg[m]) begin
            frame_count[m] = (bt.rx_byte == sync_first_cfg[m]) ? CNT_W'(1) : '0;
            return 1'b0;
        end
        if (frame_count[m] >= FRAME_BYTES) begin
            frame_count[m]  = '0;
            frame_target[m] = '0;
            return 1'b0;
        end
        frame_image[m][frame_count[m]] = bt.rx_byte;
        frame_count[m] = frame_count[m] + 1'b1;
        if (frame_count[m] > store_fill[m]) begin
            store_fill[m] = frame_count[m];
        end
        if (frame_count[m] == LEN_READY_COUNT) begin
            total = LEN_W'(HDR_BYTES) + {frame_image[m][LEN_HI_IDX], frame_image[m][LEN_LO_IDX]};
            if (total > FRAME_BYTES) begin
                frame_count[m]  = '0;
                frame_target[m] = '0;
                return 1'b0;
            end
            frame_target[m] = total[CNT_W-1:0];
        end
        if (frame_target[m] != 0 && frame_count[m] == frame_target[m]) begin
            res.frame_length = frame_count[m];
            frame_count[m]   = '0;
            frame_target[m]  = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Queues one beat and keeps the stimulus-side copy of the deframer in step.
    task automatic push_beat(input t_serial_beat b);
        t_queued_beat item;
        t_result      unused;
        item.beat        = b;
        item.drain_first = drain_next;
        drain_next       = 1'b0;
        pending_beats.push_back(item);
        beats_queued++;
        void'(deframe(GEN_COPY, b, unused));
    endtask

    task automatic push_rx(input logic [BYTE_W-1:0] value);
        push_beat('{cmd: CMD_RX, rx_byte: value,
                    read_index: CNT_W'($urandom_range(0, ADDR_MAX))});
    endtask

    task automatic push_read(input logic [CNT_W-1:0] index);
        push_beat('{cmd: CMD_READ, rx_byte: BYTE_W'($urandom_range(0, 255)),
                    read_index: index});
    endtask

    // Reads either a position that is known to hold a byte or one beyond the buffer.
    task automatic push_random_read();
        if (store_fill[GEN_COPY] == 0 || $urandom_range(0, 5) == 0) begin
            push_read(CNT_W'($urandom_range(FRAME_BYTES, ADDR_MAX)));
        end else begin
            push_read(CNT_W'($urandom_range(0, store_fill[GEN_COPY] - 1)));
        end
    endtask

    // Sends the first bytes_to_send bytes of a frame that carries len_field in its
    // length bytes; everything except the sync word and the length is random.
    task automatic push_frame(input logic [15:0] len_field, input int bytes_to_send);
        logic [BYTE_W-1:0] value;
        for (int k = 0; k < bytes_to_send; k++) begin
            case (k)
                0:          value = sync_first_cfg[GEN_COPY];
                1:          value = sync_second_cfg[GEN_COPY];
                LEN_LO_IDX: value = len_field[7:0];
                LEN_HI_IDX: value = len_field[15:8];
                default:    value = BYTE_W'($urandom_range(0, 255));
            endcase
            push_rx(value);
        end
    endtask

    // Mostly whole frames with random content and small bodies, mixed with reads,
    // line noise, broken sync words, oversized lengths and frames cut short.
    task automatic run_traffic(input int budget);
        int start_count;
        int pick;
        int body;
        start_count = beats_queued;
        while (beats_queued - start_count < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                body = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 120)
                                                   : $urandom_range(0, 8);
                push_frame(16'(body), body + HDR_BYTES);
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 4)) push_random_read();
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 5)) push_rx(BYTE_W'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                push_rx(sync_first_cfg[GEN_COPY]);
                if ($urandom_range(0, 1) == 0) begin
                    push_rx(sync_first_cfg[GEN_COPY]);
                end else begin
                    push_rx(BYTE_W'($urandom_range(0, 255)));
                end
            end else if (pick < 94) begin
                push_frame(16'($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF)),
                           LEN_READY_COUNT + $urandom_range(0, 3));
            end else if (pick < 97) begin
                push_frame(16'($urandom_range(0, 20)), $urandom_range(1, LEN_READY_COUNT + 1));
            end else begin
                drain_next = 1'b1;
            end
        end
    endtask

    // Waits until every queued beat has gone in and every expected result has come out,
    // then lets the pipeline settle.
    task automatic wait_idle(input int settle);
        @(negedge i_clk);
        while (pending_beats.size() != 0 || beat_in.valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    // Writes one sync register over the APB port and reads it back.
    task automatic write_sync_reg(input t_reg_idx idx, input logic [BYTE_W-1:0] value);
        logic [PDATA_W-1:0] junk;
        junk = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= {junk[PDATA_W-1:BYTE_W], value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[BYTE_W-1:0] !== value) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
                $display("register %s read back %0h, wrote %0h", idx.name(),
                         prdata[BYTE_W-1:0], value);
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Changes the sync word between phases, only once the block has gone quiet.
    task automatic set_sync(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
        wait_idle(4);
        write_sync_reg(REG_SYNC_FIRST, first);
        write_sync_reg(REG_SYNC_SECOND, second);
        for (int m = 0; m < 2; m++) begin
            sync_first_cfg[m]  = first;
            sync_second_cfg[m] = second;
        end
        settings_used++;
        @(negedge i_clk);
    endtask

    // Sender: bursts of random length separated by random gaps. The predictor runs on
    // every accepted beat, so expectations are queued in acceptance order.
    always @(posedge i_clk) begin : beat_driver
        int           gap_left;
        int           burst_left;
        t_queued_beat head;
        t_serial_beat seen;
        t_result      outcome;
        if (!i_rst_n) begin
            beat_in.valid <= 1'b0;
            gap_left   = 0;
            burst_left = 1;
        end else begin
            if (beat_in.valid && beat_in.ready) begin
                beats_accepted++;
                seen.cmd        = t_cmd'(beat_in.cmd);
                seen.rx_byte    = beat_in.rx_byte;
                seen.read_index = beat_in.read_index;
                if (deframe(CHECK_COPY, seen, outcome)) begin
                    expected_results.push_back(outcome);
                end
            end
            if (!beat_in.valid || beat_in.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    beat_in.valid <= 1'b0;
                end else if (pending_beats.size() == 0 ||
                             (pending_beats[0].drain_first && expected_results.size() != 0)) begin
                    // Either nothing to send, or the next beat must wait for the
                    // result queue to empty completely.
                    beat_in.valid <= 1'b0;
                end else begin
                    head = pending_beats.pop_front();
                    beat_in.valid      <= 1'b1;
                    beat_in.cmd        <= head.beat.cmd;
                    beat_in.rx_byte    <= head.beat.rx_byte;
                    beat_in.read_index <= head.beat.read_index;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Receiver: ready steps through the bits of a 16-bit mask, which is redrawn at random. A mask
    // always holds at least one set bit, and a quarter of them never stall.
    always @(posedge i_clk) begin : result_stall
        int          stall_step;
        logic [15:0] stall_mask;
        if (!i_rst_n) begin
            result_out.ready <= 1'b0;
            stall_step = 0;
            stall_mask = '1;
        end else begin
            result_out.ready <= stall_mask[stall_step[3:0]];
            stall_step++;
            if (stall_step == 64) begin
                stall_step = 0;
                case ($urandom_range(0, 3))
                    0:       stall_mask = '1;
                    1:       stall_mask = 16'($urandom()) | 16'h0001;
                    2:       stall_mask = 16'($urandom() & $urandom()) | 16'h0001;
                    default: stall_mask = ~(16'h0001 << $urandom_range(0, 15));
                endcase
            end
        end
    end

    // Result checker: every accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && result_out.valid && result_out.ready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("unexpected result: reply=%0d len=%0d data=%0h",
                             result_out.is_read_reply, result_out.frame_length,
                             result_out.read_data);
                end
            end else begin
                want = expected_results.pop_front();
                if (want.is_read_reply) begin
                    replies_seen++;
                end else begin
                    notices_seen++;
                end
                if (result_out.is_read_reply !== want.is_read_reply ||
                    result_out.frame_length !== want.frame_length ||
                    result_out.read_data !== want.read_data) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("result mismatch: want reply=%0d len=%0d data=%0h, got %0d %0d %0h",
                                 want.is_read_reply, want.frame_length, want.read_data,
                                 result_out.is_read_reply, result_out.frame_length,
                                 result_out.read_data);
                    end
                end
            end
        end
    end

    // Ends the run if no beat moves on either channel for too long.
    always @(posedge i_clk) begin : stall_watchdog
        if (!i_rst_n || (beat_in.valid && beat_in.ready) ||
            (result_out.valid && result_out.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("no beat moved for %0d cycles, %0d results outstanding", QUIET_LIMIT,
                     expected_results.size());
            $display("serial_frame_deframer_test: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        beat_in.valid      = 1'b0;
        beat_in.cmd        = 1'b0;
        beat_in.rx_byte    = '0;
        beat_in.read_index = '0;
        result_out.ready   = 1'b0;
        for (int m = 0; m < 2; m++) begin
            sync_first_cfg[m]  = '0;
            sync_second_cfg[m] = '0;
            frame_count[m]     = '0;
            frame_target[m]    = '0;
            store_fill[m]      = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: reads beyond the buffer, bytes dropped while hunting, a wrong
        // second byte that is not and one that is the first sync byte, the shortest
        // frame, and a length one past what the buffer can hold.
        set_sync(8'h47, 8'hB8);
        push_read(CNT_W'(ADDR_MAX));
        push_read(CNT_W'(FRAME_BYTES));
        push_rx(8'h00);
        push_rx(8'hFF);
        push_rx(8'h47);
        push_rx(8'h00);
        push_rx(8'h47);
        push_frame(16'd0, HDR_BYTES);
        push_frame(16'(MAX_PAYLOAD + 1), LEN_READY_COUNT);
        push_read(CNT_W'(0));
        push_read(CNT_W'(HDR_BYTES - 1));

        // A frame that fills the buffer exactly, then reads at its far end.
        set_sync(8'h00, 8'hFF);
        push_frame(16'(MAX_PAYLOAD), FRAME_BYTES);
        drain_next = 1'b1;
        push_read(CNT_W'(FRAME_BYTES - 1));
        push_read(CNT_W'(512));
        push_read(CNT_W'(FRAME_BYTES));
        run_traffic(50);

        set_sync(8'hFF, 8'h00);
        run_traffic(70);
        set_sync(8'h00, 8'h00);
        run_traffic(70);
        set_sync(8'hFF, 8'hFF);
        run_traffic(70);
        set_sync(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
        run_traffic(70);

        wait_idle(8);
        $display("covered %0d beats under %0d sync settings: %0d frame notices, %0d read replies",
                 beats_accepted, settings_used, notices_seen, replies_seen);
        if (error_count == 0) begin
            $display("serial_frame_deframer_test: done, clean");
        end else begin
            $display("%0d failures", error_count);
            $display("serial_frame_deframer_test: done, errors");
        end
        $finish;
    end

endmodule
